[hdl/slp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the sample table linear playback block.
// No dependencies; slp_ifs, slp_muldiv and the top block use this package.
package slp_pkg;

  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INTERP = 3'd0,
    ST_CONST  = 3'd1,
    ST_RANGE  = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_STORED = 3'd4,
    ST_FULL   = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONST_MODE  = 1'b0,
    CFG_CONST_LEVEL = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_WCMP,
    S_LEFT,
    S_LCMP,
    S_CALC,
    S_FIN
  } state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_phase_e;

endpackage

[hdl/slp_ifs.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response words.
// Depends on slp_pkg for the command and status field widths.
interface slp_req_if #(
  parameter int TIME_BITS  = 32,
  parameter int VALUE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic [slp_pkg::CMD_W-1:0]     cmd;
  logic [TIME_BITS-1:0]          time_req;
  logic signed [VALUE_BITS-1:0]  sample_value;

  modport source (output valid, cmd, time_req, sample_value, input ready);
  modport sink   (input valid, cmd, time_req, sample_value, output ready);
endinterface

interface slp_rsp_if #(
  parameter int VALUE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_BITS-1:0]  level;
  logic [slp_pkg::STATUS_W-1:0]  status;

  modport source (output valid, level, status, input ready);
  modport sink   (input valid, level, status, output ready);
endinterface

[hdl/sample_table_linear_playback.sv]
`timescale 1ns / 1ps
// Sample table linear playback: append and clear words maintain a table of
// (time, value) samples; a tick word walks a cursor forward to the first
// sample not earlier than the tick time and answers the linear interpolation
// between it and the previous sample (or the constant level in constant mode,
// or the held level with a flag when no value can be formed). Each request
// word gives exactly one response word; the block takes one word at a time.
// A table tick reads and compares each entry the cursor steps over and the
// one it stops on, then fetches the left sample; a walk that runs off the end
// of the table answers with the held level. When the time falls strictly
// between two samples the interpolation goes to the one-bit-per-cycle
// multiply/divide unit. The table is a single-port-read memory; its contents
// are not cleared, an entry count tracks which entries are live. A new request
// is taken while a finished response still waits in the output register; the
// next one then holds until that register drains.
// Depends on slp_pkg, slp_ifs, slp_store and slp_muldiv.
module sample_table_linear_playback #(
  parameter int TABLE_DEPTH = 1024,
  parameter int TIME_BITS   = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  slp_req_if.sink                         req_i,
  slp_rsp_if.source                       rsp_o,
  input  logic                            cfg_we_i,
  input  logic [slp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [VALUE_BITS-1:0]           cfg_data_i
);
  import slp_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic [IDX_W-1:0]      cur_q, cur_d;
  logic [TIME_BITS-1:0]  prev_q, prev_d;
  logic [TIME_BITS-1:0]  t_q, t_d;
  logic [TIME_BITS-1:0]  tr_q, tr_d;
  logic [VALUE_BITS-1:0] vr_q, vr_d;
  logic [VALUE_BITS-1:0] vl_q, vl_d;
  logic                  neg_q, neg_d;
  logic [VALUE_BITS-1:0] held_q, held_d;
  logic [VALUE_BITS-1:0] res_level_q, res_level_d;
  status_e               res_status_q, res_status_d;
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] out_level_q, out_level_d;
  status_e               out_status_q, out_status_d;

  logic                  const_mode_q;
  logic [VALUE_BITS-1:0] const_level_q;

  logic                  wr_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [TIME_BITS-1:0]  rd_time;
  logic [VALUE_BITS-1:0] rd_value;

  logic                  md_start;
  logic                  md_done;
  logic [VALUE_BITS-1:0] md_quo;
  logic [VALUE_BITS:0]   vdiff;
  logic [VALUE_BITS:0]   vdiff_neg;
  logic [VALUE_BITS-1:0] vmag;
  logic [TIME_BITS-1:0]  t_off;
  logic [TIME_BITS-1:0]  t_span;
  logic [IDX_W-1:0]      start_cur;
  logic [CNT_W-1:0]      start_cur_w;
  logic [CNT_W-1:0]      idx_m1;
  logic                  accept;
  logic                  out_free;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;

  // left/right deltas; left sample arrives on rd_* in S_LCMP
  assign vdiff     = {vr_q[VALUE_BITS-1], vr_q} - {rd_value[VALUE_BITS-1], rd_value};
  assign vdiff_neg = '0 - vdiff;
  assign vmag      = vdiff[VALUE_BITS] ? vdiff_neg[VALUE_BITS-1:0] : vdiff[VALUE_BITS-1:0];
  assign t_off     = t_q - rd_time;
  assign t_span    = tr_q - rd_time;

  // rewind the cursor when time goes backward
  assign start_cur   = (req_i.time_req < prev_q) ? '0 : cur_q;
  assign start_cur_w = CNT_W'(start_cur);
  assign idx_m1      = idx_q - CNT_W'(1);

  slp_store #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TIME_BITS   (TIME_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (cnt_q[IDX_W-1:0]),
    .wr_time_i  (req_i.time_req),
    .wr_value_i (req_i.sample_value),
    .rd_addr_i  (rd_addr),
    .rd_time_o  (rd_time),
    .rd_value_o (rd_value)
  );

  slp_muldiv #(
    .TIME_BITS  (TIME_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .mag_i   (vmag),
    .mul_i   (t_off),
    .div_i   (t_span),
    .done_o  (md_done),
    .quo_o   (md_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      const_mode_q  <= 1'b0;
      const_level_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CONST_MODE:  const_mode_q  <= cfg_data_i[0];
        CFG_CONST_LEVEL: const_level_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      idx_q        <= '0;
      cur_q        <= '0;
      prev_q       <= '0;
      t_q          <= '0;
      tr_q         <= '0;
      vr_q         <= '0;
      vl_q         <= '0;
      neg_q        <= 1'b0;
      held_q       <= '0;
      res_level_q  <= '0;
      res_status_q <= ST_INTERP;
      out_valid_q  <= 1'b0;
      out_level_q  <= '0;
      out_status_q <= ST_INTERP;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      idx_q        <= idx_d;
      cur_q        <= cur_d;
      prev_q       <= prev_d;
      t_q          <= t_d;
      tr_q         <= tr_d;
      vr_q         <= vr_d;
      vl_q         <= vl_d;
      neg_q        <= neg_d;
      held_q       <= held_d;
      res_level_q  <= res_level_d;
      res_status_q <= res_status_d;
      out_valid_q  <= out_valid_d;
      out_level_q  <= out_level_d;
      out_status_q <= out_status_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    t_d          = t_q;
    tr_d         = tr_q;
    vr_d         = vr_q;
    vl_d         = vl_q;
    neg_d        = neg_q;
    held_d       = held_q;
    res_level_d  = res_level_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_level_d  = out_level_q;
    out_status_d = out_status_q;
    wr_en        = 1'b0;
    rd_addr      = idx_q[IDX_W-1:0];
    md_start     = 1'b0;
    req_i.ready  = 1'b0;

    case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (accept) begin
          res_level_d = held_q;
          state_d     = S_FIN;
          case (cmd_e'(req_i.cmd))
            CMD_TICK: begin
              if (const_mode_q) begin
                res_level_d  = const_level_q;
                res_status_d = ST_CONST;
              end else if (cnt_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                cur_d   = start_cur;
                prev_d  = req_i.time_req;
                t_d     = req_i.time_req;
                idx_d   = (start_cur_w >= cnt_q) ? cnt_q : start_cur_w;
                state_d = S_WALK;
              end
            end
            CMD_APPEND: begin
              if (cnt_q >= CNT_W'(TABLE_DEPTH)) begin
                res_status_d = ST_FULL;
              end else begin
                wr_en        = 1'b1;
                cnt_d        = cnt_q + CNT_W'(1);
                res_status_d = ST_STORED;
              end
            end
            CMD_CLEAR: begin
              cnt_d        = '0;
              cur_d        = '0;
              prev_d       = '0;
              res_status_d = ST_STORED;
            end
            default: res_status_d = ST_RANGE;
          endcase
        end
      end
      S_WALK: begin
        if (idx_q >= cnt_q) begin
          res_level_d  = held_q;
          res_status_d = ST_RANGE;
          state_d      = S_FIN;
        end else begin
          state_d = S_WCMP;
        end
      end
      S_WCMP: begin
        if (rd_time < t_q) begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_WALK;
        end else if (idx_q == '0) begin
          // first sample at or after the tick time
          state_d = S_FIN;
          if (rd_time == t_q) begin
            res_level_d  = rd_value;
            res_status_d = ST_INTERP;
          end else begin
            res_level_d  = held_q;
            res_status_d = ST_RANGE;
          end
        end else begin
          tr_d    = rd_time;
          vr_d    = rd_value;
          cur_d   = idx_q[IDX_W-1:0];
          state_d = S_LEFT;
        end
      end
      S_LEFT: begin
        rd_addr = idx_m1[IDX_W-1:0];
        state_d = S_LCMP;
      end
      S_LCMP: begin
        res_status_d = ST_INTERP;
        if (t_q <= rd_time) begin
          res_level_d = rd_value;
          state_d     = S_FIN;
        end else if (t_q >= tr_q) begin
          res_level_d = vr_q;
          state_d     = S_FIN;
        end else begin
          vl_d     = rd_value;
          neg_d    = vdiff[VALUE_BITS];
          md_start = 1'b1;
          state_d  = S_CALC;
        end
      end
      S_CALC: begin
        if (md_done) begin
          res_level_d = neg_q ? (vl_q - md_quo) : (vl_q + md_quo);
          state_d     = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_level_d  = res_level_q;
          out_status_d = res_status_q;
          held_d       = res_level_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.level  = out_level_q;
  assign rsp_o.status = out_status_q;

endmodule

[hdl/slp_store.sv]
`timescale 1ns / 1ps
// Sample table memory: time and value arrays, one write and one read port.
// Read data is registered. Depends on nothing else.
module slp_store #(
  parameter int TABLE_DEPTH = 1024,
  parameter int TIME_BITS   = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic                           clk_i,
  input  logic                           wr_en_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr_i,
  input  logic [TIME_BITS-1:0]           wr_time_i,
  input  logic [VALUE_BITS-1:0]          wr_value_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr_i,
  output logic [TIME_BITS-1:0]           rd_time_o,
  output logic [VALUE_BITS-1:0]          rd_value_o
);

  logic [TIME_BITS-1:0]  time_mem  [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] value_mem [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      time_mem[wr_addr_i]  <= wr_time_i;
      value_mem[wr_addr_i] <= wr_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_time_o  <= time_mem[rd_addr_i];
    rd_value_o <= value_mem[rd_addr_i];
  end

endmodule

[hdl/slp_muldiv.sv]
`timescale 1ns / 1ps
// Iterative unit computing floor(mag * mul / div): shift-add multiply, then
// restoring division, one bit per cycle. Depends on slp_pkg.
module slp_muldiv #(
  parameter int TIME_BITS  = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] mag_i,
  input  logic [TIME_BITS-1:0]  mul_i,
  input  logic [TIME_BITS-1:0]  div_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] quo_o
);
  import slp_pkg::*;

  localparam int PROD_W = VALUE_BITS + TIME_BITS;
  localparam int CNT_W  = $clog2(PROD_W + 1);

  md_phase_e             phase_q, phase_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [PROD_W-1:0]     acc_q, acc_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [TIME_BITS-1:0]  mul_q, mul_d;
  logic [TIME_BITS-1:0]  div_q, div_d;
  logic [TIME_BITS-1:0]  rem_q, rem_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic                  done_q, done_d;
  logic [PROD_W-1:0]     addend;
  logic [TIME_BITS:0]    trial;
  logic [TIME_BITS:0]    trial_sub;
  logic                  fits;

  assign addend    = mul_q[TIME_BITS-1] ? {{TIME_BITS{1'b0}}, mag_q} : '0;
  assign trial     = {rem_q, acc_q[PROD_W-1]};
  assign trial_sub = trial - {1'b0, div_q};
  assign fits      = ~trial_sub[TIME_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= MD_IDLE;
      cnt_q   <= '0;
      acc_q   <= '0;
      mag_q   <= '0;
      mul_q   <= '0;
      div_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      mag_q   <= mag_d;
      mul_q   <= mul_d;
      div_q   <= div_d;
      rem_q   <= rem_d;
      quo_q   <= quo_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    mag_d   = mag_q;
    mul_d   = mul_q;
    div_d   = div_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    done_d  = 1'b0;
    case (phase_q)
      MD_IDLE: begin
        if (start_i) begin
          mag_d   = mag_i;
          mul_d   = mul_i;
          div_d   = div_i;
          acc_d   = '0;
          rem_d   = '0;
          quo_d   = '0;
          cnt_d   = CNT_W'(TIME_BITS);
          phase_d = MD_MUL;
        end
      end
      MD_MUL: begin
        // multiplier MSB first
        acc_d = (acc_q << 1) + addend;
        mul_d = mul_q << 1;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          cnt_d   = CNT_W'(PROD_W);
          phase_d = MD_DIV;
        end
      end
      MD_DIV: begin
        rem_d = fits ? trial_sub[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
        quo_d = {quo_q[VALUE_BITS-2:0], fits};
        acc_d = acc_q << 1;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          done_d  = 1'b1;
          phase_d = MD_IDLE;
        end
      end
      default: phase_d = MD_IDLE;
    endcase
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
